// ----- rtl/spring_force_3d_core_defines.svh -----
// Assertion macros shared by the spring force RTL
`ifndef SPRING_FORCE_3D_CORE_DEFINES_SVH
`define SPRING_FORCE_3D_CORE_DEFINES_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

    // fixed datapath widths
    localparam int NCOMP  = 3;
    localparam int COORD_W = 32;
    localparam int AD_W   = 33;   // |d| per axis
    localparam int SQ_W   = 66;   // squared length
    localparam int LEN_W  = 34;   // floor sqrt of squared length
    localparam int MAG_W  = 64;   // k * |L - rest|
    localparam int K_W    = 31;
    localparam int NUM_W  = MAG_W + AD_W + 1;
    localparam int Q_W    = 33;   // quotient bits kept by the divider

    localparam logic [COORD_W-1:0] F_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] F_MIN = 32'h8000_0000;
    localparam logic [Q_W-1:0]     Q_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0]     Q_NEG_LIM = 33'h0_8000_0000;

    localparam logic [K_W-1:0] K_RESET    = 31'd65536;
    localparam logic [K_W-1:0] REST_RESET = 31'd65536;

    // register map, index = paddr / 4
    typedef enum logic [2:0] {
        REG_SPRING_K = 3'd0,
        REG_REST_LEN = 3'd1,
        REG_ANCHOR_X = 3'd2,
        REG_ANCHOR_Y = 3'd3,
        REG_ANCHOR_Z = 3'd4
    } t_reg_idx;

    // data riding along the square root pipeline
    typedef struct packed {
        logic [NCOMP-1:0][AD_W-1:0] ad;
        logic [NCOMP-1:0]           pos;
        logic                       degen;
    } t_sq_side;

    // data riding along one divider
    typedef struct packed {
        logic pos;
        logic degen;
    } t_dv_side;

endpackage

// ----- rtl/sfd_sqrt.sv -----
module sfd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sfd_pkg::SQ_W-1:0]      i_sq,
    input  sfd_pkg::t_sq_side             i_side,
    output logic                          o_valid,
    output logic [sfd_pkg::LEN_W-1:0]     o_root,
    output sfd_pkg::t_sq_side             o_side
);
    import sfd_pkg::*;

    localparam int SW = 2 * LEN_W;   // radicand padded to whole bit pairs
    localparam int RW = LEN_W + 3;   // partial remainder

    logic [LEN_W:0]     r_vld;
    logic [SW-1:0]      r_s    [0:LEN_W];
    logic [RW-1:0]      r_rem  [0:LEN_W];
    logic [LEN_W-1:0]   r_root [0:LEN_W];
    t_sq_side           r_side [0:LEN_W];

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LEN_W-1:0], i_valid};
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]    <= SW'(i_sq);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // one root bit per stage, MSB first
    for (genvar k = 1; k <= LEN_W; k++) begin : g_stage
        logic [RW-1:0] n_rem;
        logic [RW-1:0] trial;
        logic          ge;

        always_comb begin
            n_rem = {r_rem[k-1][RW-3:0], r_s[k-1][SW-1 -: 2]};
            trial = RW'({r_root[k-1], 2'b01});
            ge    = (n_rem >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]    <= {r_s[k-1][SW-3:0], 2'b00};
                r_rem[k]  <= ge ? (n_rem - trial) : n_rem;
                r_root[k] <= {r_root[k-1][LEN_W-2:0], ge};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[LEN_W];
    assign o_root  = r_root[LEN_W];
    assign o_side  = r_side[LEN_W];

endmodule

// ----- rtl/sfd_div.sv -----
module sfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [sfd_pkg::NUM_W-1:0]              i_num,
    input  logic [sfd_pkg::LEN_W+FRAC_BITS-1:0]    i_den,
    input  sfd_pkg::t_dv_side                      i_side,
    output logic                                   o_valid,
    output logic [sfd_pkg::Q_W-1:0]                o_quo,
    output logic                                   o_big,
    output sfd_pkg::t_dv_side                      o_side
);
    import sfd_pkg::*;

    localparam int DW = LEN_W + FRAC_BITS;

    logic [Q_W:0]      r_vld;
    logic [DW-1:0]     r_rem  [0:Q_W];
    logic [DW-1:0]     r_den  [0:Q_W];
    logic [Q_W-1:0]    r_low  [0:Q_W];
    logic [Q_W-1:0]    r_quo  [0:Q_W];
    logic              r_big  [0:Q_W];
    t_dv_side          r_side [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-1:0], i_valid};
        end
    end

    // quotient at or above 2^Q_W is flagged; the high part then seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big[0]  <= (i_num >= NUM_W'({i_den, {Q_W{1'b0}}}));
            r_rem[0]  <= i_num[Q_W+DW-1:Q_W];
            r_low[0]  <= i_num[Q_W-1:0];
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [DW:0] n_rem;
        logic [DW:0] den_x;
        logic        ge;

        always_comb begin
            n_rem = {r_rem[k-1], r_low[k-1][Q_W-1]};
            den_x = {1'b0, r_den[k-1]};
            ge    = (n_rem >= den_x);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DW'(n_rem - den_x) : n_rem[DW-1:0];
                r_quo[k]  <= {r_quo[k-1][Q_W-2:0], ge};
                r_low[k]  <= {r_low[k-1][Q_W-2:0], 1'b0};
                r_den[k]  <= r_den[k-1];
                r_big[k]  <= r_big[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quo   = r_quo[Q_W];
    assign o_big   = r_big[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// ----- rtl/spring_force_3d_core.sv -----
// Throughput: one request per cycle; the 35-stage square root and three
// 34-stage dividers are fully pipelined and the pipeline halts as a whole only
// while a finished result is held by i_stall.
// Reset: synchronous, active low; clears all valid bits and sets
// spring_constant and rest_length to 1.0 and the anchor to the origin.
module spring_force_3d_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_particle_x,
    input  logic [31:0] i_particle_y,
    input  logic [31:0] i_particle_z,
    input  logic [31:0] i_other_x,
    input  logic [31:0] i_other_y,
    input  logic [31:0] i_other_z,
    input  logic        i_anchored,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_force_x,
    output logic [31:0] o_force_y,
    output logic [31:0] o_force_z,
    output logic        o_degenerate,
    output logic        o_saturated,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfd_pkg::*;

    `include "spring_force_3d_core_defines.svh"

    localparam int DW = LEN_W + FRAC_BITS;

    // registers
    logic [K_W-1:0]     r_spring_constant;
    logic [K_W-1:0]     r_rest_length;
    logic [COORD_W-1:0] r_anchor_x;
    logic [COORD_W-1:0] r_anchor_y;
    logic [COORD_W-1:0] r_anchor_z;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_constant <= K_RESET;
            r_rest_length     <= REST_RESET;
            r_anchor_x        <= '0;
            r_anchor_y        <= '0;
            r_anchor_z        <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SPRING_K: r_spring_constant <= pwdata[K_W-1:0];
                REG_REST_LEN: r_rest_length     <= pwdata[K_W-1:0];
                REG_ANCHOR_X: r_anchor_x        <= pwdata;
                REG_ANCHOR_Y: r_anchor_y        <= pwdata;
                REG_ANCHOR_Z: r_anchor_z        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPRING_K: prdata = 32'(r_spring_constant);
            REG_REST_LEN: prdata = 32'(r_rest_length);
            REG_ANCHOR_X: prdata = r_anchor_x;
            REG_ANCHOR_Y: prdata = r_anchor_y;
            REG_ANCHOR_Z: prdata = r_anchor_z;
            default:      prdata = '0;
        endcase
    end

    // global advance: hold everything only while a result waits
    logic r_out_valid;
    logic en;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // stage 1: separation vector, magnitude and sign per axis
    logic [COORD_W-1:0] pp   [NCOMP];
    logic [COORD_W-1:0] oth  [NCOMP];
    logic [AD_W-1:0]    dd   [NCOMP];
    logic [AD_W-1:0]    n1_ad[NCOMP];
    logic [NCOMP-1:0]   n1_pos;

    always_comb begin
        pp[0]  = i_particle_x;
        pp[1]  = i_particle_y;
        pp[2]  = i_particle_z;
        oth[0] = i_anchored ? r_anchor_x : i_other_x;
        oth[1] = i_anchored ? r_anchor_y : i_other_y;
        oth[2] = i_anchored ? r_anchor_z : i_other_z;
        for (int i = 0; i < NCOMP; i++) begin
            dd[i]     = {pp[i][COORD_W-1], pp[i]} - {oth[i][COORD_W-1], oth[i]};
            n1_ad[i]  = dd[i][AD_W-1] ? (AD_W'(0) - dd[i]) : dd[i];
            n1_pos[i] = !dd[i][AD_W-1] && (dd[i] != '0);
        end
    end

    logic                       r1_valid;
    logic [NCOMP-1:0][AD_W-1:0] r1_ad;
    logic [NCOMP-1:0]           r1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r1_ad[i] <= n1_ad[i];
            end
            r1_pos <= n1_pos;
        end
    end

    // stage 2: squares per axis
    logic                       r2_valid;
    logic [SQ_W-1:0]            r2_sq [NCOMP];
    t_sq_side                   r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r2_sq[i] <= SQ_W'(r1_ad[i] * r1_ad[i]);
            end
            r2_side.ad    <= r1_ad;
            r2_side.pos   <= r1_pos;
            r2_side.degen <= (r1_ad == '0);
        end
    end

    // squared length into the root pipeline
    logic [SQ_W-1:0]  sq_sum;
    logic             sq_valid;
    logic [LEN_W-1:0] sq_root;
    t_sq_side         sq_side;

    assign sq_sum = r2_sq[0] + r2_sq[1] + r2_sq[2];

    sfd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_sq    (sq_sum),
        .i_side  (r2_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 4: distance from rest length, divisor
    logic             r4_valid;
    logic [LEN_W-1:0] r4_diff;
    logic [DW-1:0]    r4_den;
    t_sq_side         r4_side;
    logic [LEN_W-1:0] rest_x;

    assign rest_x = LEN_W'(r_rest_length);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_diff <= (sq_root >= rest_x) ? (sq_root - rest_x) : (rest_x - sq_root);
            r4_den  <= {sq_root, {FRAC_BITS{1'b0}}};
            r4_side <= sq_side;
        end
    end

    // stage 5: magnitude
    logic             r5_valid;
    logic [MAG_W-1:0] r5_mag;
    logic [DW-1:0]    r5_den;
    t_sq_side         r5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mag  <= MAG_W'(r_spring_constant * r4_diff);
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // stage 6: magnitude * |d| as two half products per axis
    logic                 r6_valid;
    logic [AD_W+31:0]     r6_lo [NCOMP];
    logic [AD_W+31:0]     r6_hi [NCOMP];
    logic [DW-1:0]        r6_den;
    t_sq_side             r6_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r6_lo[i] <= r5_mag[31:0]  * r5_side.ad[i];
                r6_hi[i] <= r5_mag[63:32] * r5_side.ad[i];
            end
            r6_den  <= r5_den;
            r6_side <= r5_side;
        end
    end

    // stage 7: dividend with rounding half
    logic               r7_valid;
    logic [NUM_W-1:0]   r7_num [NCOMP];
    logic [DW-1:0]      r7_den;
    t_sq_side           r7_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r7_num[i] <= NUM_W'({r6_hi[i], 32'd0}) + NUM_W'(r6_lo[i])
                           + NUM_W'(r6_den >> 1);
            end
            r7_den  <= r6_den;
            r7_side <= r6_side;
        end
    end

    // valid bits for stages 4 to 7
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= sq_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    // one divider per axis
    logic [NCOMP-1:0] dv_valid;
    logic [Q_W-1:0]   dv_quo  [NCOMP];
    logic [NCOMP-1:0] dv_big;
    t_dv_side         dv_side [NCOMP];

    for (genvar g = 0; g < NCOMP; g++) begin : g_div
        t_dv_side dv_in;

        assign dv_in.pos   = r7_side.pos[g];
        assign dv_in.degen = r7_side.degen;

        sfd_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r7_valid),
            .i_num   (r7_num[g]),
            .i_den   (r7_den),
            .i_side  (dv_in),
            .o_valid (dv_valid[g]),
            .o_quo   (dv_quo[g]),
            .o_big   (dv_big[g]),
            .o_side  (dv_side[g])
        );
    end

    // clamp, apply sign opposite to d
    logic [COORD_W-1:0] n_force [NCOMP];
    logic [NCOMP-1:0]   n_sat;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            if (dv_side[i].degen) begin
                n_sat[i]   = 1'b0;
                n_force[i] = '0;
            end else if (dv_side[i].pos) begin
                n_sat[i]   = dv_big[i] || (dv_quo[i] > Q_NEG_LIM);
                n_force[i] = n_sat[i] ? F_MIN : (COORD_W'(0) - dv_quo[i][COORD_W-1:0]);
            end else begin
                n_sat[i]   = dv_big[i] || (dv_quo[i] > Q_POS_LIM);
                n_force[i] = n_sat[i] ? F_MAX : dv_quo[i][COORD_W-1:0];
            end
        end
    end

    // output register
    logic [COORD_W-1:0] r_force [NCOMP];
    logic               r_degen;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NCOMP; i++) begin
                r_force[i] <= n_force[i];
            end
            r_degen <= dv_side[0].degen;
            r_sat   <= |n_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_force_x    = r_force[0];
    assign o_force_y    = r_force[1];
    assign o_force_z    = r_force[2];
    assign o_degenerate = r_degen;
    assign o_saturated  = r_sat;

    // checks
    `SFD_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && !o_saturated,
        "degenerate result carries a force")
    `SFD_ASSERT_IMP(a_sat_clipped, i_clk, i_rst_n, o_valid && o_saturated,
        o_force_x == F_MAX || o_force_x == F_MIN || o_force_y == F_MAX ||
        o_force_y == F_MIN || o_force_z == F_MAX || o_force_z == F_MIN,
        "saturated flag without a clipped component")
    `SFD_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, o_stall,
        $stable(r1_valid) && $stable(r7_valid),
        "pipeline moved while held")

endmodule

// ----- dv/spring_force_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, result and register channels of the spring force core,
// works out the expected force for every accepted request and compares.
module spring_force_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_particle_x,
    input  logic [31:0] i_particle_y,
    input  logic [31:0] i_particle_z,
    input  logic [31:0] i_other_x,
    input  logic [31:0] i_other_y,
    input  logic [31:0] i_other_z,
    input  logic        i_anchored,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_force_x,
    input  logic [31:0] o_force_y,
    input  logic [31:0] o_force_z,
    input  logic        o_degenerate,
    input  logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import sfd_pkg::*;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        degen;
        logic        sat;
    } t_force;

    // shadow of the register file
    logic [30:0] stiffness;
    logic [30:0] rest_len;
    logic [31:0] anchor [3];

    t_force force_queue [$];

    // Hooke force on the particle, exact integer arithmetic at the block's widths
    function automatic t_force spring_force(input logic [31:0] pos [3],
                                            input logic [31:0] far_end [3]);
        logic signed [32:0] d [3];
        logic [32:0]  ad [3];
        logic [67:0]  sq;
        logic [33:0]  len;
        logic [33:0]  trial;
        logic [33:0]  diff;
        logic [63:0]  mag;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] q;
        logic [31:0]  f [3];
        t_force       res;
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i]  = $signed({pos[i][31], pos[i]}) - $signed({far_end[i][31], far_end[i]});
            ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            sq    = sq + 68'(ad[i]) * 68'(ad[i]);
        end
        res = '0;
        if (sq == 0) begin
            res.degen = 1'b1;
            return res;
        end
        // floor square root, one bit per step from the top
        len = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = len | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= sq) len = trial;
        end
        diff = (len >= 34'(rest_len)) ? len - 34'(rest_len) : 34'(rest_len) - len;
        mag  = 64'(128'(stiffness) * 128'(diff));
        den  = 128'(len) << FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            num = 128'(mag) * 128'(ad[i]) + (den >> 1);
            q   = num / den;
            // force points against d, clipped to the signed 32-bit range
            if (d[i] > 0) begin
                if (q > 128'(Q_NEG_LIM)) begin
                    f[i] = F_MIN;
                    res.sat = 1'b1;
                end else begin
                    f[i] = 32'(-q[31:0]);
                end
            end else begin
                if (q > 128'(Q_POS_LIM)) begin
                    f[i] = F_MAX;
                    res.sat = 1'b1;
                end else begin
                    f[i] = q[31:0];
                end
            end
        end
        res.fx = f[0];
        res.fy = f[1];
        res.fz = f[2];
        return res;
    endfunction

    assign o_pending = force_queue.size();

    always @(posedge i_clk) begin
        logic [31:0] pos [3];
        logic [31:0] far_end [3];
        t_force      exp_f;
        if (!i_rst_n) begin
            stiffness    <= K_RESET;
            rest_len     <= REST_RESET;
            anchor[0]    <= '0;
            anchor[1]    <= '0;
            anchor[2]    <= '0;
            o_fail_count <= 0;
            force_queue.delete();
        end else begin
            // register writes; unmapped indexes fall through
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_SPRING_K: stiffness <= pwdata[30:0];
                    REG_REST_LEN: rest_len  <= pwdata[30:0];
                    REG_ANCHOR_X: anchor[0] <= pwdata;
                    REG_ANCHOR_Y: anchor[1] <= pwdata;
                    REG_ANCHOR_Z: anchor[2] <= pwdata;
                    default: ;
                endcase
            end
            // accepted request
            if (i_valid && !o_stall) begin
                pos[0] = i_particle_x;
                pos[1] = i_particle_y;
                pos[2] = i_particle_z;
                if (i_anchored) begin
                    far_end = anchor;
                end else begin
                    far_end[0] = i_other_x;
                    far_end[1] = i_other_y;
                    far_end[2] = i_other_z;
                end
                force_queue.insert(force_queue.size(), spring_force(pos, far_end));
            end
            // accepted result
            if (o_valid && !i_stall) begin
                if (force_queue.size() == 0) begin
                    $error("unexpected result: force_x %h", o_force_x);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_f = force_queue.pop_front();
                    if (o_force_x !== exp_f.fx || o_force_y !== exp_f.fy ||
                        o_force_z !== exp_f.fz || o_degenerate !== exp_f.degen ||
                        o_saturated !== exp_f.sat)
                        o_fail_count <= o_fail_count + 1;
                    if (o_force_x !== exp_f.fx)
                        $error("force_x: expected %h, got %h", exp_f.fx, o_force_x);
                    if (o_force_y !== exp_f.fy)
                        $error("force_y: expected %h, got %h", exp_f.fy, o_force_y);
                    if (o_force_z !== exp_f.fz)
                        $error("force_z: expected %h, got %h", exp_f.fz, o_force_z);
                    if (o_degenerate !== exp_f.degen)
                        $error("degenerate: expected %b, got %b", exp_f.degen, o_degenerate);
                    if (o_saturated !== exp_f.sat)
                        $error("saturated: expected %b, got %b", exp_f.sat, o_saturated);
                end
            end
        end
    end

endmodule

// ----- dv/tb_spring_force_3d_core.sv -----
`timescale 1ns / 100ps

module tb_spring_force_3d_core;
    import sfd_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles with no traffic before giving up
    localparam int DRAIN_WAIT  = 100;    // longer than the pipeline latency
    localparam int PHASE_ITEMS = 340;
    localparam int QUIET_ITEMS = 200;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_particle_x, i_particle_y, i_particle_z;
    logic [31:0] i_other_x, i_other_y, i_other_z;
    logic        i_anchored;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_force_x, o_force_y, o_force_z;
    logic        o_degenerate;
    logic        o_saturated;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   fail_count;
    int   pending;
    int   idle_cycles;
    logic quiet;

    // local copies of what was written, for aiming requests
    logic [31:0] rest_now;
    logic [31:0] anchor_now [3];

    spring_force_3d_core dut (.*);

    spring_force_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_particle_x, .i_particle_y, .i_particle_z,
        .i_other_x, .i_other_y, .i_other_z, .i_anchored,
        .o_valid, .i_stall, .o_force_x, .o_force_y, .o_force_z,
        .o_degenerate, .o_saturated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on traffic of any kind
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side back-pressure in bursts
    initial begin
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REST_LEN: rest_now      = {1'b0, val[30:0]};
            REG_ANCHOR_X: anchor_now[0] = val;
            REG_ANCHOR_Y: anchor_now[1] = val;
            REG_ANCHOR_Z: anchor_now[2] = val;
            default: ;
        endcase
    endtask

    // hold the request until it is taken, then maybe leave a gap
    task automatic send_request(input logic [31:0] p [3], input logic [31:0] o [3],
                                input logic anch);
        i_valid      <= 1'b1;
        i_particle_x <= p[0];
        i_particle_y <= p[1];
        i_particle_z <= p[2];
        i_other_x    <= o[0];
        i_other_y    <= o[1];
        i_other_z    <= o[2];
        i_anchored   <= anch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // wait for every result, then let the pipeline empty
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] center);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return center + $urandom_range(0, 255) - 128;
            default: return center + $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    task automatic random_request();
        logic [31:0] p [3];
        logic [31:0] o [3];
        logic [31:0] center;
        logic        anch;
        int          kind;
        kind = $urandom_range(0, 99);
        anch = (kind < 25);
        for (int i = 0; i < 3; i++) begin
            center = anch ? anchor_now[i] : $urandom;
            p[i]   = near(center);
            o[i]   = anch ? $urandom : near(center);
        end
        if (kind >= 94 && kind < 97) begin
            // zero separation
            o = p;
            anch = 1'b0;
        end else if (kind >= 97) begin
            // exactly at rest length along x
            o    = p;
            o[0] = p[0] - rest_now;
            anch = 1'b0;
        end
        send_request(p, o, anch);
    endtask

    task automatic directed_requests();
        logic [31:0] z [3];
        logic [31:0] p [3];
        logic [31:0] o [3];
        z = '{32'd0, 32'd0, 32'd0};
        send_request(z, z, 1'b0);                                  // zero length
        send_request(z, '{32'hFFFF_FFFF, 32'h1234, 32'h5}, 1'b1);  // zero to anchor
        send_request('{32'h0001_0000, 32'd0, 32'd0}, z, 1'b0);     // at rest
        send_request('{32'd0, 32'h0001_0000, 32'd0}, z, 1'b1);     // at rest, anchored
        p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_request(p, o, 1'b0);                                  // largest separation
        send_request(o, p, 1'b0);
        send_request(o, z, 1'b1);
        send_request(p, z, 1'b1);
        send_request('{32'h0003_0000, 32'd0, 32'd0}, z, 1'b0);
        send_request('{32'd0, 32'hFFFD_0000, 32'd0}, z, 1'b0);
        send_request('{32'd0, 32'd0, 32'h0000_0001}, z, 1'b0);     // tiny length
        send_request('{32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000}, z, 1'b0);
        send_request('{32'h0100_0000, 32'd0, 32'd0}, z, 1'b0);
        send_request(z, '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001}, 1'b0);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                reg_write(REG_SPRING_K, 32'h7FFF_FFFF);
                reg_write(REG_REST_LEN, 32'd0);
                reg_write(REG_ANCHOR_X, 32'h8000_0000);
                reg_write(REG_ANCHOR_Y, 32'h7FFF_FFFF);
                reg_write(REG_ANCHOR_Z, 32'd0);
                reg_write(REG_UNMAPPED, 32'hDEAD_BEEF);
            end
            2: begin
                reg_write(REG_SPRING_K, 32'd0);
                reg_write(REG_REST_LEN, 32'hFFFF_FFFF);
                reg_write(REG_ANCHOR_X, $urandom);
                reg_write(REG_ANCHOR_Y, $urandom);
                reg_write(REG_ANCHOR_Z, $urandom);
            end
            default: begin
                reg_write(REG_SPRING_K, $urandom_range(0, 1 << 20));
                reg_write(REG_REST_LEN, $urandom_range(0, 1 << 21));
                reg_write(REG_ANCHOR_X, $urandom);
                reg_write(REG_ANCHOR_Y, $urandom);
                reg_write(REG_ANCHOR_Z, $urandom);
            end
        endcase
    endtask

    initial begin
        quiet        = 1'b0;
        rest_now     = 32'h0001_0000;
        anchor_now   = '{32'd0, 32'd0, 32'd0};
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_particle_x <= '0;
        i_particle_y <= '0;
        i_particle_z <= '0;
        i_other_x    <= '0;
        i_other_y    <= '0;
        i_other_z    <= '0;
        i_anchored   <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, then stiffer, slacker and random springs
        directed_requests();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase != 0) begin
                drain();
                configure(phase);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == PHASE_ITEMS - QUIET_ITEMS) quiet = 1'b1;
                random_request();
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_sqrt.sv
rtl/sfd_div.sv
rtl/spring_force_3d_core.sv
dv/spring_force_checker.sv
dv/tb_spring_force_3d_core.sv
